// ----- hw/rtl/box_om_pkg.sv -----
// Shared widths, select codes and stage payload types for the box overlap metrics block.
`timescale 1ns / 1ps

package box_om_pkg;

    localparam int COORD_W    = 16;
    localparam int EXT_W      = COORD_W + 1;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int AREA_W     = 2 * EXT_W;
    localparam int AREA_DEN_W = PROD_W + 1;
    localparam int PROJ_DEN_W = COORD_W;
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;
    localparam int NUM_RATIO  = 3;
    localparam int NUM_PROJ   = 4;

    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC{1'b0}}};

    typedef logic [1:0] sel_t;

    localparam sel_t SEL_ZERO = 2'd0;
    localparam sel_t SEL_ONE  = 2'd1;
    localparam sel_t SEL_DIV  = 2'd2;

    typedef struct packed {
        logic [PROD_W-1:0]           overlap;
        sel_t [NUM_RATIO-1:0]        ratio_sel;
        sel_t [NUM_PROJ-1:0]         proj_sel;
        logic                        proj_ok;
        logic                        err;
    } side_t;

    typedef struct packed {
        logic [NUM_RATIO-1:0][AREA_DEN_W-1:0] r_num;
        logic [NUM_RATIO-1:0][AREA_DEN_W-1:0] r_den;
        logic [NUM_PROJ-1:0][PROJ_DEN_W-1:0]  p_num;
        logic [NUM_PROJ-1:0][PROJ_DEN_W-1:0]  p_den;
        side_t                                side;
    } div_in_t;

endpackage

// ----- hw/rtl/box_overlap_metrics.sv -----
// Top level of the box overlap metrics block: stage control, dividers and output skid.
`timescale 1ns / 1ps

// Scores a pair of axis-aligned boxes: intersection area, IoU, coverage of
// each box, and box A's corners in box B's normalized frame. One item can be
// accepted every clock cycle while the skid entry is free. An item passes
// through three front stages (extents, area multipliers, operand setup), a
// 16-stage divider pipeline that resolves one quotient bit per stage, and
// the output register, the first of these loaded at the accepting edge. A
// two-entry output buffer lets the input keep flowing after the output
// stalls until the skid entry is full; after that the whole pipeline holds
// until the result is taken.
module box_overlap_metrics
    import box_om_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] a_x1,
    input  logic signed [COORD_W-1:0] a_y1,
    input  logic signed [COORD_W-1:0] a_x2,
    input  logic signed [COORD_W-1:0] a_y2,
    input  logic signed [COORD_W-1:0] b_x1,
    input  logic signed [COORD_W-1:0] b_y1,
    input  logic signed [COORD_W-1:0] b_x2,
    input  logic signed [COORD_W-1:0] b_y2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [PROD_W-1:0]         overlap_area,
    output logic [RATIO_W-1:0]        iou_ratio,
    output logic [RATIO_W-1:0]        cover_of_a,
    output logic [RATIO_W-1:0]        cover_of_b,
    output logic [RATIO_W-1:0]        proj_left,
    output logic [RATIO_W-1:0]        proj_top,
    output logic [RATIO_W-1:0]        proj_right,
    output logic [RATIO_W-1:0]        proj_bottom,
    output logic                      proj_valid,
    output logic                      ratio_error
);

    localparam int NUM_STAGES = 3 + RATIO_FRAC;

    typedef struct packed {
        logic [PROD_W-1:0]  overlap;
        logic [RATIO_W-1:0] iou;
        logic [RATIO_W-1:0] cov_a;
        logic [RATIO_W-1:0] cov_b;
        logic [RATIO_W-1:0] pl;
        logic [RATIO_W-1:0] pt;
        logic [RATIO_W-1:0] pr;
        logic [RATIO_W-1:0] pb;
        logic               pvalid;
        logic               err;
    } res_t;

    function automatic logic [RATIO_W-1:0] pick(input sel_t sel,
                                                input logic [RATIO_FRAC-1:0] q);
        case (sel)
            SEL_ONE:  pick = RATIO_ONE;
            SEL_DIV:  pick = {1'b0, q};
            default:  pick = '0;
        endcase
    endfunction

    logic                   adv;
    logic [NUM_STAGES-1:0]  v_reg;
    div_in_t                div_in;
    side_t                  side_reg [RATIO_FRAC];
    logic [RATIO_FRAC-1:0]  q_r [NUM_RATIO];
    logic [RATIO_FRAC-1:0]  q_p [NUM_PROJ];

    // The pipeline moves as a whole whenever the skid entry is free.
    assign in_ready = adv;

    box_om_front u_front (
        .clk  (clk),
        .en   (adv),
        .a_x1 (a_x1),
        .a_y1 (a_y1),
        .a_x2 (a_x2),
        .a_y2 (a_y2),
        .b_x1 (b_x1),
        .b_y1 (b_y1),
        .b_x2 (b_x2),
        .b_y2 (b_y2),
        .dout (div_in)
    );

    genvar i;
    generate
        for (i = 0; i < NUM_RATIO; i++)
        begin : g_rdiv
            box_om_div #(.WIDTH(AREA_DEN_W)) u_div (
                .clk (clk),
                .en  (adv),
                .num (div_in.r_num[i]),
                .den (div_in.r_den[i]),
                .quo (q_r[i])
            );
        end
        for (i = 0; i < NUM_PROJ; i++)
        begin : g_pdiv
            box_om_div #(.WIDTH(PROJ_DEN_W)) u_div (
                .clk (clk),
                .en  (adv),
                .num (div_in.p_num[i]),
                .den (div_in.p_den[i]),
                .quo (q_p[i])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= div_in.side;
            for (int k = 1; k < RATIO_FRAC; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NUM_STAGES-2:0], in_valid};
        end
    end

    // Final selection and projection validity.
    side_t                   side_last;
    logic [RATIO_W-1:0]      pl_raw, pt_raw, pr_raw, pb_raw;
    logic signed [RATIO_W:0] pw, ph;
    res_t                    res_next;

    always_comb
    begin
        side_last = side_reg[RATIO_FRAC-1];
        pl_raw    = pick(side_last.proj_sel[0], q_p[0]);
        pt_raw    = pick(side_last.proj_sel[1], q_p[1]);
        pr_raw    = pick(side_last.proj_sel[2], q_p[2]);
        pb_raw    = pick(side_last.proj_sel[3], q_p[3]);
        pw        = $signed({1'b0, pr_raw}) - $signed({1'b0, pl_raw});
        ph        = $signed({1'b0, pb_raw}) - $signed({1'b0, pt_raw});

        res_next.overlap = side_last.overlap;
        res_next.iou     = pick(side_last.ratio_sel[0], q_r[0]);
        res_next.cov_a   = pick(side_last.ratio_sel[1], q_r[1]);
        res_next.cov_b   = pick(side_last.ratio_sel[2], q_r[2]);
        res_next.pvalid  = side_last.proj_ok
                         && (((pw > 0) && (ph > 0)) || ((pw < 0) && (ph < 0)));
        res_next.pl      = res_next.pvalid ? pl_raw : '0;
        res_next.pt      = res_next.pvalid ? pt_raw : '0;
        res_next.pr      = res_next.pvalid ? pr_raw : '0;
        res_next.pb      = res_next.pvalid ? pb_raw : '0;
        res_next.err     = side_last.err;
    end

    // Output register plus one skid entry.
    logic out_valid_reg, skid_valid_reg;
    logic out_free;
    res_t out_reg, skid_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign adv      = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= v_reg[NUM_STAGES-1];
        end
        else
        begin
            skid_valid_reg <= v_reg[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_free)
        begin
            out_reg <= res_next;
        end
        else
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign overlap_area = out_reg.overlap;
    assign iou_ratio    = out_reg.iou;
    assign cover_of_a   = out_reg.cov_a;
    assign cover_of_b   = out_reg.cov_b;
    assign proj_left    = out_reg.pl;
    assign proj_top     = out_reg.pt;
    assign proj_right   = out_reg.pr;
    assign proj_bottom  = out_reg.pb;
    assign proj_valid   = out_reg.pvalid;
    assign ratio_error  = out_reg.err;

    // An invalid projection always reports zero corners.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !proj_valid) |-> (proj_left == '0 && proj_top == '0
                                        && proj_right == '0 && proj_bottom == '0))
        else $error("invalid projection carries nonzero corners");

    // No overlap means every area ratio is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overlap_area == '0) |-> (iou_ratio == '0 && cover_of_a == '0
                                               && cover_of_b == '0))
        else $error("ratio nonzero without overlap");

    // Ratios never exceed 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iou_ratio <= RATIO_ONE && cover_of_a <= RATIO_ONE
                       && cover_of_b <= RATIO_ONE))
        else $error("ratio above one");

    // The skid entry only fills while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without output stall");

endmodule

// ----- hw/rtl/box_om_div.sv -----
// Pipelined restoring fraction divider, one quotient bit per stage.
`timescale 1ns / 1ps

module box_om_div
    import box_om_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [WIDTH-1:0]      num,
    input  logic [WIDTH-1:0]      den,
    output logic [RATIO_FRAC-1:0] quo
);

    logic [WIDTH-1:0]      rem_reg [RATIO_FRAC-1];
    logic [WIDTH-1:0]      den_reg [RATIO_FRAC-1];
    logic [RATIO_FRAC-1:0] quo_reg [RATIO_FRAC];

    genvar j;
    generate
        for (j = 0; j < RATIO_FRAC; j++)
        begin : g_step
            logic [WIDTH-1:0]      r_in;
            logic [WIDTH-1:0]      d_in;
            logic [RATIO_FRAC-1:0] q_in;
            logic [WIDTH:0]        sh;
            logic                  ge;
            logic [WIDTH-1:0]      rem_next;
            logic [RATIO_FRAC-1:0] quo_next;

            if (j == 0)
            begin : g_first
                assign r_in = num;
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign r_in = rem_reg[j-1];
                assign d_in = den_reg[j-1];
                assign q_in = quo_reg[j-1];
            end

            // The remainder stays below the divisor, so the doubled value fits one extra bit.
            always_comb
            begin
                sh       = {r_in, 1'b0};
                ge       = (sh >= {1'b0, d_in});
                rem_next = ge ? WIDTH'(sh - {1'b0, d_in}) : sh[WIDTH-1:0];
                quo_next = {q_in[RATIO_FRAC-2:0], ge};
            end

            if (j < RATIO_FRAC - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j] <= rem_next;
                        den_reg[j] <= d_in;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[j] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[RATIO_FRAC-1];

endmodule

// ----- hw/rtl/box_om_front.sv -----
// Front stages: overlap extents, area products and divider operand setup.
`timescale 1ns / 1ps

module box_om_front
    import box_om_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] a_x1,
    input  logic signed [COORD_W-1:0] a_y1,
    input  logic signed [COORD_W-1:0] a_x2,
    input  logic signed [COORD_W-1:0] a_y2,
    input  logic signed [COORD_W-1:0] b_x1,
    input  logic signed [COORD_W-1:0] b_y1,
    input  logic signed [COORD_W-1:0] b_x2,
    input  logic signed [COORD_W-1:0] b_y2,
    output div_in_t                   dout
);

    function automatic logic signed [EXT_W-1:0] diff(input logic signed [COORD_W-1:0] p,
                                                     input logic signed [COORD_W-1:0] q);
        diff = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    endfunction

    // Stage 1: extents.
    logic signed [COORD_W-1:0] ix_hi, ix_lo, iy_hi, iy_lo;
    logic signed [EXT_W-1:0]   iw_s, ih_s;
    logic [COORD_W-1:0]        iw_next, ih_next;
    logic                      disj_next;
    logic signed [EXT_W-1:0]   pn_next [NUM_PROJ];

    logic [COORD_W-1:0]        iw_reg, ih_reg;
    logic signed [EXT_W-1:0]   aw_reg, ah_reg, bw_reg, bh_reg;
    logic signed [EXT_W-1:0]   pn_reg [NUM_PROJ];
    logic                      disj_reg;

    always_comb
    begin
        ix_hi   = (a_x2 < b_x2) ? a_x2 : b_x2;
        ix_lo   = (a_x1 > b_x1) ? a_x1 : b_x1;
        iy_hi   = (a_y2 < b_y2) ? a_y2 : b_y2;
        iy_lo   = (a_y1 > b_y1) ? a_y1 : b_y1;
        iw_s    = diff(ix_hi, ix_lo);
        ih_s    = diff(iy_hi, iy_lo);
        iw_next = iw_s[EXT_W-1] ? '0 : iw_s[EXT_W-2:0];
        ih_next = ih_s[EXT_W-1] ? '0 : ih_s[EXT_W-2:0];
        disj_next = (a_x1 >= b_x2) || (a_x2 <= b_x1) || (a_y1 >= b_y2) || (a_y2 <= b_y1);
        pn_next[0] = diff(a_x1, b_x1);
        pn_next[1] = diff(a_y1, b_y1);
        pn_next[2] = diff(a_x2, b_x1);
        pn_next[3] = diff(a_y2, b_y1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iw_reg   <= iw_next;
            ih_reg   <= ih_next;
            aw_reg   <= diff(a_x2, a_x1);
            ah_reg   <= diff(a_y2, a_y1);
            bw_reg   <= diff(b_x2, b_x1);
            bh_reg   <= diff(b_y2, b_y1);
            disj_reg <= disj_next;
            for (int i = 0; i < NUM_PROJ; i++)
            begin
                pn_reg[i] <= pn_next[i];
            end
        end
    end

    // Stage 2: area products.
    logic [PROD_W-1:0]        inter_reg;
    logic signed [AREA_W-1:0] area_a_reg, area_b_reg;
    logic signed [EXT_W-1:0]  bw2_reg, bh2_reg;
    logic signed [EXT_W-1:0]  pn2_reg [NUM_PROJ];
    logic                     disj2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inter_reg  <= iw_reg * ih_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
            bw2_reg    <= bw_reg;
            bh2_reg    <= bh_reg;
            disj2_reg  <= disj_reg;
            for (int i = 0; i < NUM_PROJ; i++)
            begin
                pn2_reg[i] <= pn_reg[i];
            end
        end
    end

    // Stage 3: union, special cases and divider operands.
    logic signed [AREA_W:0]   inter_s;
    logic signed [AREA_W:0]   rd [NUM_RATIO];
    logic signed [EXT_W-1:0]  pd [NUM_PROJ];
    logic                     proj_ok;
    logic                     err_any;
    div_in_t                  dout_next;
    div_in_t                  dout_reg;

    always_comb
    begin
        inter_s = $signed({3'b000, inter_reg});
        rd[0]   = $signed({area_a_reg[AREA_W-1], area_a_reg})
                + $signed({area_b_reg[AREA_W-1], area_b_reg}) - inter_s;
        rd[1]   = $signed({area_a_reg[AREA_W-1], area_a_reg});
        rd[2]   = $signed({area_b_reg[AREA_W-1], area_b_reg});
        pd[0]   = bw2_reg;
        pd[1]   = bh2_reg;
        pd[2]   = bw2_reg;
        pd[3]   = bh2_reg;
        proj_ok = !disj2_reg && (bw2_reg > 0) && (bh2_reg > 0);
        err_any = !disj2_reg && !((bw2_reg > 0) && (bh2_reg > 0));

        dout_next = '0;
        dout_next.side.overlap = inter_reg;
        for (int i = 0; i < NUM_RATIO; i++)
        begin
            dout_next.r_num[i] = {1'b0, inter_reg};
            dout_next.r_den[i] = rd[i][AREA_DEN_W-1:0];
            if (rd[i] <= 0)
            begin
                dout_next.side.ratio_sel[i] = SEL_ZERO;
                err_any = 1'b1;
            end
            else if (inter_reg == '0)
            begin
                dout_next.side.ratio_sel[i] = SEL_ZERO;
            end
            else if (inter_s >= rd[i])
            begin
                dout_next.side.ratio_sel[i] = SEL_ONE;
            end
            else
            begin
                dout_next.side.ratio_sel[i] = SEL_DIV;
            end
        end
        for (int i = 0; i < NUM_PROJ; i++)
        begin
            dout_next.p_num[i] = pn2_reg[i][PROJ_DEN_W-1:0];
            dout_next.p_den[i] = pd[i][PROJ_DEN_W-1:0];
            if (!proj_ok || (pn2_reg[i] <= 0))
            begin
                dout_next.side.proj_sel[i] = SEL_ZERO;
            end
            else if (pn2_reg[i] >= pd[i])
            begin
                dout_next.side.proj_sel[i] = SEL_ONE;
            end
            else
            begin
                dout_next.side.proj_sel[i] = SEL_DIV;
            end
        end
        dout_next.side.proj_ok = proj_ok;
        dout_next.side.err     = err_any;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
